// ----- src/gs5x8_pkg.sv -----
// ----------------------------------------------------------------------------
// gs5x8_pkg
// Shared types, constants and the 5x8 font for the glyph scaler.
// ----------------------------------------------------------------------------
package gs5x8_pkg;

   localparam int GLYPH_COLUMNS = 5;
   localparam int GLYPH_BITS    = 8 * GLYPH_COLUMNS;

   // addresses cover the largest buffer (4096 bytes) and the largest unwrapped
   // address that the parameter ranges allow
   localparam int ADDR_W = 12;

   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] ROW_LAST_SINGLE = CNT_W'(GLYPH_COLUMNS - 1);
   localparam logic [CNT_W-1:0] ROW_LAST_DOUBLE = CNT_W'(2 * GLYPH_COLUMNS - 1);

   localparam logic [7:0] CODE_FIRST  = 8'h20;
   localparam logic [7:0] CODE_LAST   = 8'h7E;
   localparam logic [7:0] CODE_SUBST  = 8'h23;
   localparam logic [7:0] LOWER_FIRST = 8'h61;
   localparam logic [7:0] LOWER_LAST  = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic [1:0] SCALE_DOUBLE = 2'd2;

   localparam logic CSR_IDX_LOWERCASE = 1'b0;

   // one glyph job handed from the front to the back
   typedef struct packed {
      logic [GLYPH_BITS-1:0] cols;     // column 0 in the top byte
      logic                  dbl;
      logic [ADDR_W-1:0]     wrap_hi;
      logic [ADDR_W-1:0]     unw_hi;
      logic [ADDR_W-1:0]     wrap_lo;
      logic [ADDR_W-1:0]     unw_lo;
   } job_type;

   function automatic logic [7:0] column_byte(logic [GLYPH_BITS-1:0] cols, logic [2:0] col);
      logic [7:0] b;
      case (col)
         3'd0: b = cols[39:32];
         3'd1: b = cols[31:24];
         3'd2: b = cols[23:16];
         3'd3: b = cols[15:8];
         3'd4: b = cols[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [GLYPH_BITS-1:0] glyph_cols(logic [6:0] idx);
      logic [GLYPH_BITS-1:0] g;
      case (idx)
         7'd0:  g = 40'h0000000000;
         7'd1:  g = 40'h000CBE0C00;
         7'd2:  g = 40'h0E06000E06;
         7'd3:  g = 40'h48FC48FC48;
         7'd4:  g = 40'h4856D42400;
         7'd5:  g = 40'hC62610C8C6;
         7'd6:  g = 40'h6C92AC40A0;
         7'd7:  g = 40'h000E060000;
         7'd8:  g = 40'h007C820000;
         7'd9:  g = 40'h00827C0000;
         7'd10: g = 40'h107C387C10;
         7'd11: g = 40'h10107C1010;
         7'd12: g = 40'h00E0600000;
         7'd13: g = 40'h1010101010;
         7'd14: g = 40'h0060600000;
         7'd15: g = 40'h4020100804;
         7'd16: g = 40'h7CA2928A7C;
         7'd17: g = 40'h0084FE8000;
         7'd18: g = 40'hC4A292928C;
         7'd19: g = 40'h449292926C;
         7'd20: g = 40'h302824FE20;
         7'd21: g = 40'h5E92929262;
         7'd22: g = 40'h7894929260;
         7'd23: g = 40'h02E2120A06;
         7'd24: g = 40'h6C9292926C;
         7'd25: g = 40'h0C9292523C;
         7'd26: g = 40'h006C6C0000;
         7'd27: g = 40'h00EC6C0000;
         7'd28: g = 40'h1028448200;
         7'd29: g = 40'h4848484848;
         7'd30: g = 40'h0082442810;
         7'd31: g = 40'h0402B2120C;
         7'd32: g = 40'h7C82BAAA3C;
         7'd33: g = 40'hFC222222FC;
         7'd34: g = 40'hFE9292926C;
         7'd35: g = 40'h7C82828244;
         7'd36: g = 40'hFE8282827C;
         7'd37: g = 40'hFE92929282;
         7'd38: g = 40'hFE12121202;
         7'd39: g = 40'h7C829292F4;
         7'd40: g = 40'hFE101010FE;
         7'd41: g = 40'h0082FE8200;
         7'd42: g = 40'h608080807E;
         7'd43: g = 40'hFE10284482;
         7'd44: g = 40'hFE80808080;
         7'd45: g = 40'hFE040804FE;
         7'd46: g = 40'hFE040810FE;
         7'd47: g = 40'h7C8282827C;
         7'd48: g = 40'hFE1212120C;
         7'd49: g = 40'h7C82A242BC;
         7'd50: g = 40'hFE121232CC;
         7'd51: g = 40'h4C92929264;
         7'd52: g = 40'h0202FE0202;
         7'd53: g = 40'h7E8080807E;
         7'd54: g = 40'h3E4080403E;
         7'd55: g = 40'h7E8078807E;
         7'd56: g = 40'hC6281028C6;
         7'd57: g = 40'h0E10E0100E;
         7'd58: g = 40'hE2928A8600;
         7'd59: g = 40'h00FE828200;
         7'd60: g = 40'h0408102040;
         7'd61: g = 40'h008282FE00;
         7'd62: g = 40'h0804020408;
         7'd63: g = 40'h8080808080;
         7'd64: g = 40'h00060E0000;
         7'd65: g = 40'h40A8A8A8F0;
         7'd66: g = 40'hFE88888870;
         7'd67: g = 40'h7088888800;
         7'd68: g = 40'h70888888FE;
         7'd69: g = 40'h70A8A8A810;
         7'd70: g = 40'h10FC121200;
         7'd71: g = 40'h10A8A8A878;
         7'd72: g = 40'hFE0808F000;
         7'd73: g = 40'h0000FA8000;
         7'd74: g = 40'h4080887A00;
         7'd75: g = 40'hFE20508800;
         7'd76: g = 40'h0000FE8000;
         7'd77: g = 40'hF8083008F0;
         7'd78: g = 40'hF80808F000;
         7'd79: g = 40'h7088888870;
         7'd80: g = 40'hF828282810;
         7'd81: g = 40'h70888888F8;
         7'd82: g = 40'h88F0880810;
         7'd83: g = 40'h10A8A8A840;
         7'd84: g = 40'h087C884800;
         7'd85: g = 40'h788040F800;
         7'd86: g = 40'h3840804038;
         7'd87: g = 40'h78C060C078;
         7'd88: g = 40'h8850205088;
         7'd89: g = 40'h3840C07800;
         7'd90: g = 40'hC8A8A89800;
         7'd91: g = 40'h107C828200;
         7'd92: g = 40'h0000FF0000;
         7'd93: g = 40'h0082827C10;
         7'd94: g = 40'h0402040200;
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

// ----- src/gs5x8_front.sv -----
// ----------------------------------------------------------------------------
// gs5x8_front
// Takes request words, picks the glyph and works out the wrapped and
// unwrapped start addresses of both page rows.
// ----------------------------------------------------------------------------
module gs5x8_front #(
   parameter int FRAME_WIDTH = 128,
   parameter int FRAME_ROWS  = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                lowercase,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_char_code,
   input  logic [1:0]          req_scale,
   input  logic [6:0]          req_column_x,
   input  logic [5:0]          req_row_y,
   output logic                push,
   output gs5x8_pkg::job_type  push_job,
   input  logic                queue_full
);

   localparam int BUF_BYTES  = FRAME_WIDTH * FRAME_ROWS / 8;
   localparam int PAGE_SLOTS = 9;
   localparam int X_SLOTS    = 128;
   localparam int SUM_W      = gs5x8_pkg::ADDR_W + 1;

   logic [gs5x8_pkg::ADDR_W-1:0] page_base [PAGE_SLOTS];
   logic [gs5x8_pkg::ADDR_W-1:0] page_mod  [PAGE_SLOTS];
   logic [gs5x8_pkg::ADDR_W-1:0] x_mod     [X_SLOTS];

   for (genvar g = 0; g < PAGE_SLOTS; g++) begin : g_page
      assign page_base[g] = gs5x8_pkg::ADDR_W'(g * FRAME_WIDTH);
      assign page_mod[g]  = gs5x8_pkg::ADDR_W'((g * FRAME_WIDTH) % BUF_BYTES);
   end

   for (genvar g = 0; g < X_SLOTS; g++) begin : g_col
      assign x_mod[g] = gs5x8_pkg::ADDR_W'(g % BUF_BYTES);
   end

   // both operands are below the buffer size, so one subtract wraps the sum
   function automatic logic [gs5x8_pkg::ADDR_W-1:0] mod_add(
      logic [gs5x8_pkg::ADDR_W-1:0] a, logic [gs5x8_pkg::ADDR_W-1:0] b);
      logic [SUM_W-1:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= SUM_W'(BUF_BYTES)) begin
         s = s - SUM_W'(BUF_BYTES);
      end
      return s[gs5x8_pkg::ADDR_W-1:0];
   endfunction

   logic                 valid_ff, valid_in;
   gs5x8_pkg::job_type   job_ff, job_in;
   logic                 accept;
   logic [7:0]           code;
   logic [3:0]           page_hi, page_lo;

   assign push      = valid_ff && !queue_full;
   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push_job  = job_ff;

   always_comb begin
      code = req_char_code;
      if (code < gs5x8_pkg::CODE_FIRST || code > gs5x8_pkg::CODE_LAST) begin
         code = gs5x8_pkg::CODE_SUBST;
      end
      if (!lowercase && code >= gs5x8_pkg::LOWER_FIRST && code <= gs5x8_pkg::LOWER_LAST) begin
         code = code - gs5x8_pkg::CASE_OFFSET;
      end

      page_hi = {1'b0, req_row_y[5:3]};
      page_lo = page_hi + 4'd1;

      job_in.cols    = gs5x8_pkg::glyph_cols(7'(code - gs5x8_pkg::CODE_FIRST));
      job_in.dbl     = (req_scale == gs5x8_pkg::SCALE_DOUBLE);
      job_in.unw_hi  = page_base[page_hi] + gs5x8_pkg::ADDR_W'(req_column_x);
      job_in.unw_lo  = page_base[page_lo] + gs5x8_pkg::ADDR_W'(req_column_x);
      job_in.wrap_hi = mod_add(page_mod[page_hi], x_mod[req_column_x]);
      job_in.wrap_lo = mod_add(page_mod[page_lo], x_mod[req_column_x]);

      valid_in = accept || (valid_ff && !push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

endmodule

// ----- src/gs5x8_queue.sv -----
// ----------------------------------------------------------------------------
// gs5x8_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module gs5x8_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gs5x8_pkg::job_type  push_job,
   output logic                full,
   input  logic                pop,
   output gs5x8_pkg::job_type  head_job,
   output logic                empty
);

   localparam int DEPTH = 2;

   gs5x8_pkg::job_type  entry_ff [DEPTH];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;

   assign full     = (count_ff == 2'(DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- src/gs5x8_back.sv -----
// ----------------------------------------------------------------------------
// gs5x8_back
// Walks the columns of one glyph job and, while rsp_stall is low, sends one
// pixel word per cycle into the result register.
// ----------------------------------------------------------------------------
module gs5x8_back #(
   parameter int FRAME_WIDTH = 128,
   parameter int FRAME_ROWS  = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  gs5x8_pkg::job_type  head_job,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_pixel_byte,
   output logic [9:0]          rsp_buffer_address,
   output logic                rsp_off_buffer,
   output logic                rsp_last
);

   localparam int BUF_BYTES = FRAME_WIDTH * FRAME_ROWS / 8;
   localparam int CMP_W     = gs5x8_pkg::ADDR_W + 1;

   function automatic logic [7:0] double_nibble(logic [3:0] nib);
      logic [7:0] r;
      for (int i = 0; i < 4; i++) begin
         r[2*i]   = nib[i];
         r[2*i+1] = nib[i];
      end
      return r;
   endfunction

   logic                          act_ff, act_in;
   gs5x8_pkg::job_type            job_ff, job_in;
   logic [gs5x8_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                          lo_ff, lo_in;
   logic [gs5x8_pkg::ADDR_W-1:0]  wrap_ff, wrap_in;
   logic [gs5x8_pkg::ADDR_W-1:0]  unw_ff, unw_in;

   logic                          valid_ff, valid_in;
   logic [7:0]                    byte_ff, byte_in;
   logic [9:0]                    addr_ff, addr_in;
   logic                          off_ff, off_in;
   logic                          last_ff, last_in;

   gs5x8_pkg::job_type            cur;
   logic [gs5x8_pkg::CNT_W-1:0]   cur_cnt;
   logic                          cur_lo;
   logic [gs5x8_pkg::ADDR_W-1:0]  cur_wrap, cur_unw, wrap_inc;
   logic [2:0]                    col;
   logic [7:0]                    col_byte;
   logic                          out_free, emit, row_end;

   assign rsp_valid          = valid_ff;
   assign rsp_pixel_byte     = byte_ff;
   assign rsp_buffer_address = addr_ff;
   assign rsp_off_buffer     = off_ff;
   assign rsp_last           = last_ff;

   always_comb begin
      out_free = !valid_ff || !rsp_stall;
      emit     = out_free && (act_ff || !empty);
      pop      = out_free && !act_ff && !empty;

      // a fresh job starts straight from the queue head
      cur      = act_ff ? job_ff : head_job;
      cur_cnt  = act_ff ? cnt_ff : '0;
      cur_lo   = act_ff && lo_ff;
      cur_wrap = act_ff ? wrap_ff : head_job.wrap_hi;
      cur_unw  = act_ff ? unw_ff : head_job.unw_hi;

      col      = cur.dbl ? cur_cnt[3:1] : cur_cnt[2:0];
      col_byte = gs5x8_pkg::column_byte(cur.cols, col);
      row_end  = cur.dbl ? (cur_cnt == gs5x8_pkg::ROW_LAST_DOUBLE)
                         : (cur_cnt == gs5x8_pkg::ROW_LAST_SINGLE);

      wrap_inc = cur_wrap + gs5x8_pkg::ADDR_W'(1);
      if ({1'b0, wrap_inc} == CMP_W'(BUF_BYTES)) begin
         wrap_inc = '0;
      end

      byte_in = col_byte;
      if (cur.dbl) begin
         byte_in = cur_lo ? double_nibble(col_byte[7:4]) : double_nibble(col_byte[3:0]);
      end
      addr_in = cur_wrap[9:0];
      off_in  = ({1'b0, cur_unw} >= CMP_W'(BUF_BYTES));
      last_in = row_end && (!cur.dbl || cur_lo);

      act_in  = act_ff;
      job_in  = job_ff;
      cnt_in  = cnt_ff;
      lo_in   = lo_ff;
      wrap_in = wrap_ff;
      unw_in  = unw_ff;
      if (emit) begin
         job_in = cur;
         if (last_in) begin
            act_in = 1'b0;
         end else if (row_end) begin
            // upper page row done, continue in the page below
            act_in  = 1'b1;
            cnt_in  = '0;
            lo_in   = 1'b1;
            wrap_in = cur.wrap_lo;
            unw_in  = cur.unw_lo;
         end else begin
            act_in  = 1'b1;
            cnt_in  = cur_cnt + gs5x8_pkg::CNT_W'(1);
            lo_in   = cur_lo;
            wrap_in = wrap_inc;
            unw_in  = cur_unw + gs5x8_pkg::ADDR_W'(1);
         end
      end

      valid_in = emit || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         act_ff   <= act_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      cnt_ff  <= cnt_in;
      lo_ff   <= lo_in;
      wrap_ff <= wrap_in;
      unw_ff  <= unw_in;
      if (emit) begin
         byte_ff <= byte_in;
         addr_ff <= addr_in;
         off_ff  <= off_in;
         last_ff <= last_in;
      end
   end

endmodule

// ----- src/glyph_scaler_5x8.sv -----
// ----------------------------------------------------------------------------
// glyph_scaler_5x8
// Character generator for a page-organized monochrome frame buffer.
// ----------------------------------------------------------------------------
// Each request word (character code, scale, pixel column and row) becomes the
// column bytes of a 5x8 font glyph with their frame-buffer addresses: 5 result
// words at scale 1 and 20 at scale 2 (upper page row left to right, then the
// lower page row), the last one flagged. While rsp_stall is low the back end
// sends one result word per cycle with no gap between glyphs, and the result
// channel sets the sustained rate. The first result word of a request passes
// through the front-end register, the queue and the result register, and a
// two-entry queue behind the front end lets new requests in while a glyph is
// still being sent. Codes outside the printable range draw as '#'; clearing
// the lowercase register folds lowercase letters to capitals. Addresses past
// the buffer end are flagged and wrap modulo FRAME_WIDTH*FRAME_ROWS/8.
// ----------------------------------------------------------------------------
module glyph_scaler_5x8 #(
   parameter int FRAME_WIDTH = 128,
   parameter int FRAME_ROWS  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic [1:0]  req_scale,
   input  logic [6:0]  req_column_x,
   input  logic [5:0]  req_row_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pixel_byte,
   output logic [9:0]  rsp_buffer_address,
   output logic        rsp_off_buffer,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                lowercase_ff, lowercase_in;
   logic                push, queue_full, pop, queue_empty;
   gs5x8_pkg::job_type  push_job, head_job;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == gs5x8_pkg::CSR_IDX_LOWERCASE) ? {31'b0, lowercase_ff} : '0;

   always_comb begin
      lowercase_in = lowercase_ff;
      if (psel && penable && pwrite && pready && paddr[2] == gs5x8_pkg::CSR_IDX_LOWERCASE) begin
         lowercase_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowercase_ff <= 1'b1;
      end else begin
         lowercase_ff <= lowercase_in;
      end
   end

   gs5x8_front #(
      .FRAME_WIDTH (FRAME_WIDTH),
      .FRAME_ROWS  (FRAME_ROWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .lowercase     (lowercase_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_scale     (req_scale),
      .req_column_x  (req_column_x),
      .req_row_y     (req_row_y),
      .push          (push),
      .push_job      (push_job),
      .queue_full    (queue_full)
   );

   gs5x8_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   gs5x8_back #(
      .FRAME_WIDTH (FRAME_WIDTH),
      .FRAME_ROWS  (FRAME_ROWS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head_job           (head_job),
      .empty              (queue_empty),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_byte     (rsp_pixel_byte),
      .rsp_buffer_address (rsp_buffer_address),
      .rsp_off_buffer     (rsp_off_buffer),
      .rsp_last           (rsp_last)
   );

endmodule
